// ===== src/gha_pkg.sv =====
// Package for the generational handle allocator.
// Holds sizes, function and status codes, the controller state type and the
// structs that travel between the controller, the memories and the top level.
package gha_pkg;

    localparam int SLOT_COUNT = 16384;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int GEN_W      = 16;
    localparam int HALF_W     = 16;
    localparam int HANDLE_W   = 32;
    localparam int CMP_W      = HALF_W + 1;
    localparam int THR_W      = 14;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;

    localparam logic [THR_W-1:0] THR_RESET = 14'd1024;

    localparam logic [FUNC_W-1:0] FN_ALLOC    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE     = 2'd1;
    localparam logic [FUNC_W-1:0] FN_VALIDATE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NEVER_ALLOC = 2'd2;
    localparam logic [STATUS_W-1:0] ST_QUEUE_FULL  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_QWAIT,
        S_GWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [HANDLE_W-1:0] new_handle;
        logic                alive;
        logic [STATUS_W-1:0] status;
    } t_result;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [GEN_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_gen_port;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_queue_port;

endpackage

// ===== src/gha_req_if.sv =====
// Request channel of the handle allocator: valid/ready plus function and handle.
// Depends on gha_pkg for field widths.
interface gha_req_if
    import gha_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, output func, output handle, input ready);
    modport sink   (input valid, input func, input handle, output ready);
endinterface

// ===== src/gha_rsp_if.sv =====
// Response channel of the handle allocator: valid/ready plus result fields.
// Depends on gha_pkg for field widths.
interface gha_rsp_if
    import gha_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] new_handle;
    logic                alive;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output new_handle, output alive, output status,
                    input ready);
    modport sink   (input valid, input new_handle, input alive, input status,
                    output ready);
endinterface

// ===== src/gha_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/gha_ctrl.sv =====
// Sequencer of the handle allocator: decodes one request, reads and writes
// the generation and free-queue memories, and keeps the queue pointers.
// Depends on gha_pkg and gha_req_if.
module gha_ctrl
    import gha_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    gha_req_if.sink       i_req,
    input  logic          i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_wdata,
    output t_gen_port     o_gen,
    input  logic [GEN_W-1:0] i_gen_rdata,
    output t_queue_port   o_queue,
    input  logic [IDX_W-1:0] i_queue_rdata,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output t_result       o_res
);
    t_state r_state, n_state;

    logic [FUNC_W-1:0]   r_func;
    logic [HANDLE_W-1:0] r_handle;
    logic [IDX_W-1:0]    r_idx;
    t_result             r_res, n_res;
    logic                res_ld;

    logic [IDX_W-1:0]    r_head, r_tail;
    logic [CNT_W-1:0]    r_count, r_fresh;
    logic [THR_W-1:0]    r_thr;

    logic                accept;
    logic                reuse, in_range, q_full, fresh_ok;
    logic [IDX_W-1:0]    slot_idx;
    logic [GEN_W-1:0]    alloc_gen;

    assign accept   = i_req.valid && i_req.ready;
    assign reuse    = r_count > CNT_W'(r_thr);
    assign in_range = CMP_W'(r_handle[HALF_W-1:0]) < CMP_W'(r_fresh);
    assign q_full   = r_count == CNT_W'(SLOT_COUNT);
    assign fresh_ok = r_fresh != CNT_W'(SLOT_COUNT);
    assign slot_idx = r_handle[IDX_W-1:0];

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(SLOT_COUNT - 1)) ? '0 : p + 1'b1;
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (r_func)
                    FN_ALLOC:    n_state = reuse ? S_QWAIT : S_OUT;
                    FN_FREE:     n_state = (in_range && !q_full) ? S_GWAIT : S_OUT;
                    FN_VALIDATE: n_state = in_range ? S_GWAIT : S_OUT;
                    default:     n_state = S_OUT;
                endcase
            end
            S_QWAIT: n_state = S_GWAIT;
            S_GWAIT: n_state = S_OUT;
            S_OUT: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: memory requests and result
    always_comb begin
        o_gen         = '0;
        o_queue       = '0;
        n_res         = '0;
        res_ld        = 1'b0;
        alloc_gen     = '0;
        o_gen.raddr   = (r_state == S_QWAIT) ? i_queue_rdata : slot_idx;
        o_queue.raddr = r_head;
        i_req.ready   = (r_state == S_IDLE);
        o_res_valid   = (r_state == S_OUT);
        case (r_state)
            S_DECODE: begin
                res_ld = 1'b1;
                case (r_func)
                    FN_ALLOC: begin
                        if (!reuse) begin
                            if (fresh_ok) begin
                                // slot 0 at generation 0 would be the null handle
                                alloc_gen = (r_fresh == '0) ? GEN_W'(1) : '0;
                                o_gen.we    = 1'b1;
                                o_gen.waddr = r_fresh[IDX_W-1:0];
                                o_gen.wdata = alloc_gen;
                                n_res.new_handle = {alloc_gen, HALF_W'(r_fresh[IDX_W-1:0])};
                            end else begin
                                n_res.status = ST_NO_SLOT;
                            end
                        end
                    end
                    FN_FREE: begin
                        if (!in_range)   n_res.status = ST_NEVER_ALLOC;
                        else if (q_full) n_res.status = ST_QUEUE_FULL;
                    end
                    FN_VALIDATE: begin
                        if (!in_range) n_res.status = ST_NEVER_ALLOC;
                    end
                    default: n_res = '0;
                endcase
            end
            S_GWAIT: begin
                res_ld = 1'b1;
                case (r_func)
                    FN_ALLOC: begin
                        alloc_gen = i_gen_rdata;
                        if (r_idx == '0 && i_gen_rdata == '0) begin
                            alloc_gen   = GEN_W'(1);
                            o_gen.we    = 1'b1;
                            o_gen.waddr = r_idx;
                            o_gen.wdata = alloc_gen;
                        end
                        n_res.new_handle = {alloc_gen, HALF_W'(r_idx)};
                    end
                    FN_FREE: begin
                        o_gen.we      = 1'b1;
                        o_gen.waddr   = slot_idx;
                        o_gen.wdata   = i_gen_rdata + 1'b1;
                        o_queue.we    = 1'b1;
                        o_queue.waddr = r_tail;
                        o_queue.wdata = slot_idx;
                    end
                    FN_VALIDATE: begin
                        n_res.alive = (i_gen_rdata == r_handle[HANDLE_W-1:HALF_W]);
                    end
                    default: n_res = '0;
                endcase
            end
            default: res_ld = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_fresh <= '0;
            r_thr   <= THR_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (r_state == S_DECODE && r_func == FN_ALLOC && !reuse && fresh_ok) begin
                r_fresh <= r_fresh + 1'b1;
            end
            if (r_state == S_QWAIT) begin
                r_head  <= ring_next(r_head);
                r_count <= r_count - 1'b1;
            end
            if (r_state == S_GWAIT && r_func == FN_FREE) begin
                r_tail  <= ring_next(r_tail);
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_req.func;
            r_handle <= i_req.handle;
        end
        if (r_state == S_QWAIT) begin
            r_idx <= i_queue_rdata;
        end
        if (res_ld) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;
endmodule

// ===== src/generational_handle_allocator.sv =====
// Generational handle allocator, top level.
// Channels: i_req carries one request item (func: allocate, free, validate;
// handle for free and validate). o_rsp returns exactly one result item per
// request: new_handle (slot index low 16 bits, generation high 16), alive
// and status. i_cfg_we/i_cfg_wdata write the reuse threshold; write it only
// while no request is in flight.
// After the accepting edge the sequencer decodes the request. A fresh
// allocate, a rejected request or an unused function code then goes to
// the result; free and validate first read the generation memory, and an
// allocate that reuses a freed slot reads the free queue and then the
// generation memory. One request is in work at a time, and the sequencer
// returns to idle before it takes the next.
// The output register frees the sequencer: the next request is accepted
// while a result waits on a stalled receiver, and its result waits in the
// sequencer until the output register drains.
// Reset (synchronous, active low) empties the free queue, restarts fresh
// slots at 0 and sets the threshold to 1024; memory contents are kept and
// entries are only read after being written.
// Depends on gha_pkg, gha_req_if, gha_rsp_if, gha_ram and gha_ctrl.
module generational_handle_allocator
    import gha_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    gha_req_if.sink          i_req,
    gha_rsp_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_wdata
);
    t_gen_port        gen_port;
    t_queue_port      queue_port;
    logic [GEN_W-1:0] gen_rdata;
    logic [IDX_W-1:0] queue_rdata;
    logic             res_valid, res_ready;
    t_result          res;

    logic             r_out_valid;
    t_result          r_out;

    gha_ram #(.WIDTH(GEN_W), .DEPTH(SLOT_COUNT)) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (gen_port.we),
        .i_waddr (gen_port.waddr),
        .i_wdata (gen_port.wdata),
        .i_raddr (gen_port.raddr),
        .o_rdata (gen_rdata)
    );

    gha_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (queue_port.we),
        .i_waddr (queue_port.waddr),
        .i_wdata (queue_port.wdata),
        .i_raddr (queue_port.raddr),
        .o_rdata (queue_rdata)
    );

    gha_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_gen         (gen_port),
        .i_gen_rdata   (gen_rdata),
        .o_queue       (queue_port),
        .i_queue_rdata (queue_rdata),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.new_handle = r_out.new_handle;
    assign o_rsp.alive      = r_out.alive;
    assign o_rsp.status     = r_out.status;
endmodule

// ===== src/gha_checker.sv =====
// Port-level checks for the generational handle allocator, bound to the top.
// Depends on gha_pkg for the status codes.
module gha_checker
    import gha_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [HANDLE_W-1:0] i_rsp_new_handle,
    input logic                i_rsp_alive,
    input logic [STATUS_W-1:0] i_rsp_status
);
    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid
            && $stable(i_rsp_new_handle) && $stable(i_rsp_alive)
            && $stable(i_rsp_status))
        else $error("result changed while stalled");

    // one request at a time: no accept right after an accept
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while another is in work");

    // an error result carries neither a handle nor alive
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_new_handle == '0 && !i_rsp_alive)
        else $error("error result with handle or alive set");

    // alive comes only from a validate, which gives no handle
    a_alive_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_alive |-> i_rsp_status == ST_OK && i_rsp_new_handle == '0)
        else $error("alive set on a non-validate result");
endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_new_handle (o_rsp.new_handle),
    .i_rsp_alive      (o_rsp.alive),
    .i_rsp_status     (o_rsp.status)
);
